FILE: rtl/core/rmth_pkg.sv
// Package for the running median core: sizes, state encoding and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;
    localparam int HEAP_DEPTH  = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int AW          = $clog2(HEAP_DEPTH);        // heap address bits
    localparam int CW          = $clog2(HEAP_DEPTH + 1);    // live-entry count bits
    localparam int XW          = AW + 2;                    // child index arithmetic

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [AW-1:0]          t_addr;
    typedef logic [CW-1:0]          t_count;
    typedef logic [XW-1:0]          t_xidx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_UP,
        S_UP_CMP,
        S_RD_TOPS,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/running_median_two_heaps.sv
// Running median core: two binary heaps held in synchronous RAMs, one sequencer.
// Unless full, a request runs S_TOP, a sift-down (S_DN_RL, S_DN_RR, S_DN_CMP per level)
// where the sample displaces a top and a sift-up (S_UP, S_UP_CMP per level) in the other
// heap; every request then runs S_RD_TOPS and S_DONE. Requests are taken one at a time,
// only in S_IDLE; a result waits in the output register, S_DONE holding while it is full.
// Reset (i_rst_n, synchronous, active low) clears counts, sequencer and output valid;
// heap RAM contents are not cleared and are only read where written before.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  rmth_pkg::t_value i_s_tdata,   // [31:0] sample_value
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output rmth_pkg::t_value       o_m_tdata,   // [31:0] median_value
    output logic                   o_m_tuser    // [0] full_error
);
    import rmth_pkg::*;

    // lower heap: max-heap, upper heap: min-heap
    t_value r_mem_lo [HEAP_DEPTH];
    t_value r_mem_up [HEAP_DEPTH];
    t_value r_rd_lo, r_rd_up;

    t_state r_state, n_state;
    t_value r_val, n_val;       // value being sifted
    t_value r_t, n_t;           // value moved to the other heap
    t_value r_hl, n_hl;         // left child seen
    t_addr  r_hole, n_hole;
    t_count r_cnt_lo, n_cnt_lo, r_cnt_up, n_cnt_up;
    logic   r_cur_up, n_cur_up; // heap currently worked on
    logic   r_full, n_full;

    t_addr  rd_addr, wr_addr;
    t_value wr_data;
    logic   wr_en;

    t_count cnt_cur, cnt_oth;
    t_value rd_cur;
    t_xidx  idx_l, idx_r, cnt_x;
    t_addr  par;
    logic   out_free;

    // a ranks above b in the current heap's order
    function automatic logic above(input t_value a, input t_value b, input logic up);
        return up ? (a < b) : (a > b);
    endfunction

    assign cnt_cur  = r_cur_up ? r_cnt_up : r_cnt_lo;
    assign cnt_oth  = r_cur_up ? r_cnt_lo : r_cnt_up;
    assign rd_cur   = r_cur_up ? r_rd_up : r_rd_lo;
    assign idx_l    = {1'b0, r_hole, 1'b1};
    assign idx_r    = idx_l + t_xidx'(1);
    assign cnt_x    = t_xidx'(cnt_cur);
    assign par      = t_addr'((r_hole - t_addr'(1)) >> 1);
    assign out_free = !o_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (r_cnt_lo >= t_count'(HEAP_DEPTH)) n_state = S_RD_TOPS;
                    else                                  n_state = S_TOP;
                end
            end
            S_TOP: begin
                if (cnt_cur != '0 && above(rd_cur, r_val, r_cur_up)) n_state = S_DN_RL;
                else                                                  n_state = S_UP;
            end
            S_DN_RL: begin
                if (idx_l >= cnt_x) n_state = S_UP;
                else                n_state = S_DN_RR;
            end
            S_DN_RR: begin
                if (idx_r < cnt_x)                      n_state = S_DN_CMP;
                else if (above(rd_cur, r_val, r_cur_up)) n_state = S_DN_RL;
                else                                     n_state = S_UP;
            end
            S_DN_CMP: begin
                if (above(rd_cur, r_hl, r_cur_up) ? above(rd_cur, r_val, r_cur_up)
                                                  : above(r_hl, r_val, r_cur_up))
                    n_state = S_DN_RL;
                else
                    n_state = S_UP;
            end
            S_UP: begin
                if (r_hole == '0) n_state = S_RD_TOPS;
                else              n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (above(r_val, rd_cur, r_cur_up)) n_state = S_UP;
                else                                n_state = S_RD_TOPS;
            end
            S_RD_TOPS: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_val    = r_val;
        n_t      = r_t;
        n_hl     = r_hl;
        n_hole   = r_hole;
        n_cnt_lo = r_cnt_lo;
        n_cnt_up = r_cnt_up;
        n_cur_up = r_cur_up;
        n_full   = r_full;
        rd_addr  = '0;
        wr_addr  = r_hole;
        wr_data  = r_val;
        wr_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_val    = i_s_tdata;
                n_cur_up = (r_cnt_lo == r_cnt_up);
                n_full   = (r_cnt_lo >= t_count'(HEAP_DEPTH));
            end
            S_TOP: begin
                if (cnt_cur != '0 && above(rd_cur, r_val, r_cur_up)) begin
                    n_t    = rd_cur;      // old top leaves, sample replaces it
                    n_hole = '0;
                end else begin
                    // sample goes straight to the other heap
                    n_cur_up = !r_cur_up;
                    n_hole   = t_addr'(cnt_oth);
                    if (r_cur_up) n_cnt_lo = r_cnt_lo + t_count'(1);
                    else          n_cnt_up = r_cnt_up + t_count'(1);
                end
            end
            S_DN_RL: begin
                rd_addr = t_addr'(idx_l);
                if (idx_l >= cnt_x) begin
                    wr_en    = 1'b1;
                    n_val    = r_t;
                    n_cur_up = !r_cur_up;
                    n_hole   = t_addr'(cnt_oth);
                    if (r_cur_up) n_cnt_lo = r_cnt_lo + t_count'(1);
                    else          n_cnt_up = r_cnt_up + t_count'(1);
                end
            end
            S_DN_RR: begin
                n_hl    = rd_cur;
                rd_addr = t_addr'(idx_r);
                if (idx_r >= cnt_x) begin
                    wr_en = 1'b1;
                    if (above(rd_cur, r_val, r_cur_up)) begin
                        wr_data = rd_cur;
                        n_hole  = t_addr'(idx_l);
                    end else begin
                        n_val    = r_t;
                        n_cur_up = !r_cur_up;
                        n_hole   = t_addr'(cnt_oth);
                        if (r_cur_up) n_cnt_lo = r_cnt_lo + t_count'(1);
                        else          n_cnt_up = r_cnt_up + t_count'(1);
                    end
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (above(rd_cur, r_hl, r_cur_up) && above(rd_cur, r_val, r_cur_up)) begin
                    wr_data = rd_cur;
                    n_hole  = t_addr'(idx_r);
                end else if (!above(rd_cur, r_hl, r_cur_up)
                             && above(r_hl, r_val, r_cur_up)) begin
                    wr_data = r_hl;
                    n_hole  = t_addr'(idx_l);
                end else begin
                    n_val    = r_t;
                    n_cur_up = !r_cur_up;
                    n_hole   = t_addr'(cnt_oth);
                    if (r_cur_up) n_cnt_lo = r_cnt_lo + t_count'(1);
                    else          n_cnt_up = r_cnt_up + t_count'(1);
                end
            end
            S_UP: begin
                rd_addr = par;
                if (r_hole == '0) wr_en = 1'b1;
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (above(r_val, rd_cur, r_cur_up)) begin
                    wr_data = rd_cur;     // parent moves down into the hole
                    n_hole  = par;
                end
            end
            S_RD_TOPS: rd_addr = '0;
            S_DONE:    rd_addr = '0;
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_cur_up) r_mem_lo[wr_addr] <= wr_data;
        if (wr_en &&  r_cur_up) r_mem_up[wr_addr] <= wr_data;
        r_rd_lo <= r_mem_lo[rd_addr];
        r_rd_up <= r_mem_up[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_lo <= '0;
            r_cnt_up <= '0;
            r_cur_up <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_lo <= n_cnt_lo;
            r_cnt_up <= n_cnt_up;
            r_cur_up <= n_cur_up;
            r_full   <= n_full;
        end
        r_val  <= n_val;
        r_t    <= n_t;
        r_hl   <= n_hl;
        r_hole <= n_hole;
    end

    // output register: median from both tops, floored mean when counts match
    logic [VALUE_WIDTH:0] top_sum;
    assign top_sum = {1'b0, r_rd_lo} + {1'b0, r_rd_up};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            o_m_tdata <= (r_cnt_lo == r_cnt_up) ? top_sum[VALUE_WIDTH:1] : r_rd_lo;
            o_m_tuser <= r_full;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/rmth_checker.sv
// Port-level checker for the running median core, bound to running_median_two_heaps.
// Depends on rmth_pkg and running_median_two_heaps.
`timescale 1ns / 1ps
`default_nettype none
module rmth_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire rmth_pkg::t_value i_s_tdata,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire rmth_pkg::t_value o_m_tdata,
    input wire                   o_m_tuser
);
    import rmth_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed under stall");

    // one request at a time: no new request right after one is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    // a new result only appears with the core free again
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result without return to idle");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset state wrong");
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (.*);
`default_nettype wire
